// ----- rtl/plt_pkg.sv -----
`default_nettype none
package plt_pkg;

  localparam int TIME_W  = 32;
  localparam int REF_W   = 32;
  localparam int GRAD_W  = 48;
  localparam int DIST_W  = 33;
  localparam int DIV_W   = 50;
  localparam int PROD_W  = 81;
  localparam int CNT_W   = 6;
  localparam int PC_W    = 7;
  localparam int MEM_W   = 64;

  localparam logic       ACT_LOAD         = 1'b0;
  localparam logic       ACT_GENERATE     = 1'b1;
  localparam logic [2:0] ADDR_RUN_DELAY   = 3'd0;
  localparam logic [2:0] ADDR_POINT_COUNT = 3'd4;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_SEG,
    RD_SEGM1,
    RD_LAST
  } rd_sel_t;

  typedef enum logic [1:0] {
    RES_FIRST,
    RES_COAST,
    RES_INTERP
  } res_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     mem_write;
    logic     trk_clear;
    rd_sel_t  rd_sel;
    logic     seg_init;
    logic     seg_inc;
    logic     seg_dec;
    logic     seg_fix;
    logic     seg_commit;
    logic     coast_set;
    logic     grad_commit;
    logic     hi_latch;
    logic     lo_latch;
    logic     div_start;
    logic     div_step;
    logic     grad_load;
    logic     grad_zero;
    logic     mul_start;
    logic     mul_step;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_push;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic is_load;
    logic delay_hit;
    logic rt_ge;
    logic seg_last;
    logic seg_gt1;
    logic seg_new;
    logic dt_pos;
    logic div_done;
    logic mul_done;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/plt_in_if.sv -----
`default_nettype none
interface plt_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [5:0]  point_index;
  logic [31:0] point_time;
  logic signed [31:0] point_ref;
  logic [31:0] query_time;

  modport source (output valid, action, point_index, point_time, point_ref, query_time,
                  input ready);
  modport sink (input valid, action, point_index, point_time, point_ref, query_time,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/plt_out_if.sv -----
`default_nettype none
interface plt_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] ref_value;
  logic        running;

  modport source (output valid, ref_value, running, input ready);
  modport sink (input valid, ref_value, running, output ready);
endinterface
`default_nettype wire

// ----- rtl/plt_ram.sv -----
`default_nettype none
module plt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/plt_ctrl.sv -----
`default_nettype none
module plt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire plt_pkg::sts_t sts,
  output plt_pkg::cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_FIRST, S_FWD_RD, S_FWD_CHK, S_BWD_RD, S_BWD_CHK,
    S_COMMIT, S_GRD_HI, S_GRD_LO, S_DIV_INIT, S_DIV_RUN, S_INT_LAT,
    S_MUL_INIT, S_MUL_RUN, S_FINISH, S_COAST, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.rd_sel  = plt_pkg::RD_SEG;
    cmd.res_sel = plt_pkg::RES_INTERP;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_load) begin
          cmd.mem_write = 1'b1;
          cmd.trk_clear = 1'b1;
          state_nxt     = S_IDLE;
        end else if (sts.delay_hit) begin
          cmd.rd_sel = plt_pkg::RD_ZERO;
          state_nxt  = S_FIRST;
        end else begin
          cmd.seg_init = 1'b1;
          state_nxt    = S_FWD_RD;
        end
      end
      S_FIRST: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = plt_pkg::RES_FIRST;
        state_nxt    = S_EMIT;
      end
      S_FWD_RD: begin
        cmd.rd_sel = plt_pkg::RD_SEG;
        state_nxt  = S_FWD_CHK;
      end
      S_FWD_CHK: begin
        if (sts.rt_ge) begin
          if (sts.seg_last) begin
            cmd.coast_set = 1'b1;
            cmd.rd_sel    = plt_pkg::RD_LAST;
            state_nxt     = S_COAST;
          end else begin
            cmd.seg_inc = 1'b1;
            state_nxt   = S_FWD_RD;
          end
        end else begin
          cmd.seg_fix = 1'b1;
          state_nxt   = S_BWD_RD;
        end
      end
      S_BWD_RD: begin
        if (sts.seg_gt1) begin
          cmd.rd_sel = plt_pkg::RD_SEGM1;
          state_nxt  = S_BWD_CHK;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_BWD_CHK: begin
        if (!sts.rt_ge) begin
          cmd.seg_dec = 1'b1;
          state_nxt   = S_BWD_RD;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.seg_commit = 1'b1;
        cmd.rd_sel     = plt_pkg::RD_SEG;
        if (sts.seg_new) begin
          cmd.grad_commit = 1'b1;
          state_nxt       = S_GRD_HI;
        end else begin
          state_nxt = S_INT_LAT;
        end
      end
      S_GRD_HI: begin
        cmd.hi_latch = 1'b1;
        cmd.rd_sel   = plt_pkg::RD_SEGM1;
        state_nxt    = S_GRD_LO;
      end
      S_GRD_LO: begin
        cmd.lo_latch = 1'b1;
        state_nxt    = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        if (sts.dt_pos) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV_RUN;
        end else begin
          cmd.grad_zero = 1'b1;
          state_nxt     = S_MUL_INIT;
        end
      end
      S_DIV_RUN: begin
        if (sts.div_done) begin
          cmd.grad_load = 1'b1;
          state_nxt     = S_MUL_INIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_INT_LAT: begin
        cmd.hi_latch = 1'b1;
        state_nxt    = S_MUL_INIT;
      end
      S_MUL_INIT: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MUL_RUN;
      end
      S_MUL_RUN: begin
        if (sts.mul_done) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      S_FINISH: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = plt_pkg::RES_INTERP;
        state_nxt    = S_EMIT;
      end
      S_COAST: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = plt_pkg::RES_COAST;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.out_push = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/plt_dp.sv -----
`default_nettype none
module plt_dp #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  plt_in_if.sink             in_chan,
  plt_out_if.source          out_chan,
  input  wire logic [31:0]   run_delay,
  input  wire logic [6:0]    point_count,
  input  wire plt_pkg::cmd_t cmd,
  output plt_pkg::sts_t      sts
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = AW + 1;

  logic        act_r;
  logic [5:0]  idx_r;
  logic [31:0] ptime_r;
  logic [31:0] pref_r;
  logic [31:0] qt_r;
  logic [31:0] rt_r;
  logic [AW-1:0] seg_r, segidx_r, last_r;
  logic signed [plt_pkg::GRAD_W-1:0] grad_r;
  logic [31:0] t_hi_r, r_hi_r, t_lo_r, r_lo_r;
  logic [plt_pkg::DIV_W-1:0]  dq_r;
  logic [31:0] rem_r, dden_r;
  logic        dneg_r;
  logic [plt_pkg::CNT_W-1:0]  dcnt_r, mcnt_r;
  logic [plt_pkg::PROD_W-1:0] prod_r;
  logic [plt_pkg::GRAD_W-1:0] gm_r;
  logic        mneg_r;
  logic [31:0] res_val_r;
  logic        res_run_r;
  logic        out_valid_r;
  logic [31:0] out_val_r;
  logic        out_run_r;

  logic [31:0] pc32, n32;
  logic [NW-1:0] n_w;
  logic [AW-1:0] n_m1, raddr, waddr;
  logic          idx_ok;
  logic [plt_pkg::MEM_W-1:0] rdata;
  logic [31:0] rd_time, rd_ref;

  logic signed [32:0] num;
  logic [32:0] mag;
  logic [31:0] dt;
  logic [plt_pkg::DIV_W-1:0] dvd;
  logic [32:0] dtmp;
  logic        dge;
  logic [plt_pkg::DIV_W-1:0] q_max_pos, q_min_neg;
  logic signed [plt_pkg::GRAD_W-1:0] grad_q;

  logic [32:0] tdelta;
  logic [32:0] dm;
  logic [plt_pkg::GRAD_W-1:0] gm;
  logic [plt_pkg::GRAD_W:0]   psum;

  logic        big;
  logic [36:0] shf;
  logic signed [37:0] rsum, radd;
  logic [31:0] rsat;

  assign pc32 = 32'(point_count);
  assign n32  = (pc32 < 32'd2) ? 32'd2 :
                (pc32 > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : pc32;
  assign n_w  = NW'(n32);
  assign n_m1 = AW'(n_w - NW'(1));

  assign idx_ok = (32'(idx_r) < 32'(TABLE_DEPTH));
  assign waddr  = AW'(idx_r);

  always_comb begin
    unique case (cmd.rd_sel)
      plt_pkg::RD_ZERO:  raddr = '0;
      plt_pkg::RD_SEG:   raddr = seg_r;
      plt_pkg::RD_SEGM1: raddr = seg_r - AW'(1);
      plt_pkg::RD_LAST:  raddr = n_m1;
      default:           raddr = seg_r;
    endcase
  end

  plt_ram #(
    .WIDTH (plt_pkg::MEM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.mem_write && idx_ok),
    .waddr (waddr),
    .wdata ({ptime_r, pref_r}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_time = rdata[63:32];
  assign rd_ref  = rdata[31:0];

  assign num = $signed({r_hi_r[31], r_hi_r}) - $signed({r_lo_r[31], r_lo_r});
  assign mag = num[32] ? 33'(-num) : 33'(num);
  assign dt  = t_hi_r - t_lo_r;
  assign dvd = plt_pkg::DIV_W'({mag, 16'd0}) + plt_pkg::DIV_W'(dt[31:1]);
  assign dtmp = {rem_r, dq_r[plt_pkg::DIV_W-1]};
  assign dge  = (dtmp >= {1'b0, dden_r});

  assign q_max_pos = plt_pkg::DIV_W'({1'b0, {(plt_pkg::GRAD_W-1){1'b1}}});
  assign q_min_neg = plt_pkg::DIV_W'({1'b1, {(plt_pkg::GRAD_W-1){1'b0}}});

  always_comb begin
    if (dneg_r) begin
      if (dq_r > q_min_neg) begin
        grad_q = {1'b1, {(plt_pkg::GRAD_W-1){1'b0}}};
      end else begin
        grad_q = -$signed(dq_r[plt_pkg::GRAD_W-1:0]);
      end
    end else begin
      if (dq_r > q_max_pos) begin
        grad_q = {1'b0, {(plt_pkg::GRAD_W-1){1'b1}}};
      end else begin
        grad_q = $signed(dq_r[plt_pkg::GRAD_W-1:0]);
      end
    end
  end

  assign tdelta = {1'b0, t_hi_r} - {1'b0, rt_r};
  assign dm     = tdelta[32] ? (~tdelta + 33'd1) : tdelta;
  assign gm   = grad_r[plt_pkg::GRAD_W-1] ? plt_pkg::GRAD_W'(-grad_r) :
                plt_pkg::GRAD_W'(grad_r);
  assign psum = {1'b0, prod_r[plt_pkg::PROD_W-1:33]} +
                (prod_r[0] ? {1'b0, gm_r} : '0);

  assign big  = |prod_r[80:52];
  assign shf  = big ? (37'd1 << 36) : (37'(prod_r[51:16]) + 37'(prod_r[15]));
  assign radd = mneg_r ? $signed({1'b0, shf}) : -$signed({1'b0, shf});
  assign rsum = $signed({{6{r_hi_r[31]}}, r_hi_r}) + radd;

  always_comb begin
    if ((rsum[37:31] == 7'h00) || (rsum[37:31] == 7'h7f)) begin
      rsat = rsum[31:0];
    end else if (rsum[37]) begin
      rsat = 32'h8000_0000;
    end else begin
      rsat = 32'h7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && cmd.in_ready) begin
      act_r   <= in_chan.action;
      idx_r   <= in_chan.point_index;
      ptime_r <= in_chan.point_time;
      pref_r  <= in_chan.point_ref;
      qt_r    <= in_chan.query_time;
    end
    if (cmd.seg_init) begin
      rt_r <= qt_r - run_delay;
    end
    if (cmd.hi_latch) begin
      t_hi_r <= rd_time;
      r_hi_r <= rd_ref;
    end
    if (cmd.lo_latch) begin
      t_lo_r <= rd_time;
      r_lo_r <= rd_ref;
    end
    if (cmd.div_start) begin
      dq_r   <= dvd;
      rem_r  <= '0;
      dden_r <= dt;
      dneg_r <= num[32];
    end else if (cmd.div_step) begin
      dq_r  <= {dq_r[plt_pkg::DIV_W-2:0], dge};
      rem_r <= dge ? 32'(dtmp - {1'b0, dden_r}) : dtmp[31:0];
    end
    if (cmd.mul_start) begin
      prod_r <= plt_pkg::PROD_W'(dm);
      gm_r   <= gm;
      mneg_r <= tdelta[32] ^ grad_r[plt_pkg::GRAD_W-1];
    end else if (cmd.mul_step) begin
      prod_r <= {psum, prod_r[32:1]};
    end
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        plt_pkg::RES_FIRST: begin
          res_val_r <= rd_ref;
          res_run_r <= 1'b1;
        end
        plt_pkg::RES_COAST: begin
          res_val_r <= rd_ref;
          res_run_r <= 1'b0;
        end
        default: begin
          res_val_r <= rsat;
          res_run_r <= 1'b1;
        end
      endcase
    end
    if (cmd.out_push) begin
      out_val_r <= res_val_r;
      out_run_r <= res_run_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r       <= '0;
      segidx_r    <= '0;
      last_r      <= '0;
      grad_r      <= '0;
      dcnt_r      <= '0;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.trk_clear) begin
        segidx_r <= '0;
        last_r   <= '0;
      end
      if (cmd.seg_init) begin
        seg_r <= ({1'b0, segidx_r} >= n_w) ? n_m1 : segidx_r;
      end else if (cmd.seg_inc) begin
        seg_r <= seg_r + AW'(1);
      end else if (cmd.seg_dec) begin
        seg_r <= seg_r - AW'(1);
      end else if (cmd.seg_fix && (seg_r == '0)) begin
        seg_r <= AW'(1);
      end
      if (cmd.seg_commit) begin
        segidx_r <= seg_r;
      end else if (cmd.coast_set) begin
        segidx_r <= n_m1;
      end
      if (cmd.grad_commit) begin
        last_r <= seg_r;
      end
      if (cmd.grad_zero) begin
        grad_r <= '0;
      end else if (cmd.grad_load) begin
        grad_r <= grad_q;
      end
      if (cmd.div_start) begin
        dcnt_r <= plt_pkg::CNT_W'(plt_pkg::DIV_W);
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r - plt_pkg::CNT_W'(1);
      end
      if (cmd.mul_start) begin
        mcnt_r <= plt_pkg::CNT_W'(plt_pkg::DIST_W);
      end else if (cmd.mul_step) begin
        mcnt_r <= mcnt_r - plt_pkg::CNT_W'(1);
      end
      if (cmd.out_push) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_chan.ready      = cmd.in_ready;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.ref_value = out_val_r;
  assign out_chan.running   = out_run_r;

  assign sts.in_valid  = in_chan.valid;
  assign sts.is_load   = (act_r == plt_pkg::ACT_LOAD);
  assign sts.delay_hit = (qt_r <= run_delay);
  assign sts.rt_ge     = (rt_r >= rd_time);
  assign sts.seg_last  = (({1'b0, seg_r} + NW'(1)) >= n_w);
  assign sts.seg_gt1   = (seg_r > AW'(1));
  assign sts.seg_new   = (seg_r != last_r);
  assign sts.dt_pos    = (t_hi_r > t_lo_r);
  assign sts.div_done  = (dcnt_r == '0);
  assign sts.mul_done  = (mcnt_r == '0);
  assign sts.out_busy  = out_valid_r;

endmodule
`default_nettype wire

// ----- rtl/piecewise_linear_table_generator.sv -----
// A load writes one table point. A generate inside the run delay returns the first
// point's reference, one at or past the last point returns the last one's, and one
// inside the table finds its segment, recomputes the gradient on a segment change
// (zero for a zero-length segment) and interpolates. A serial divider and multiplier
// each take one bit per cycle; one transaction runs at a time. Synchronous active-low
// reset clears segment tracking, gradient, output valid, run delay; point count is 2.
`default_nettype none
module piecewise_linear_table_generator #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  plt_in_if.sink           in_chan,
  plt_out_if.source        out_chan,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  logic [31:0] run_delay_r;
  logic [6:0]  point_count_r;
  plt_pkg::cmd_t cmd;
  plt_pkg::sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_delay_r   <= '0;
      point_count_r <= 7'd2;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr == plt_pkg::ADDR_POINT_COUNT) begin
        point_count_r <= cfg_pwdata[6:0];
      end else if (cfg_paddr == plt_pkg::ADDR_RUN_DELAY) begin
        run_delay_r <= cfg_pwdata;
      end
    end
  end

  assign cfg_prdata = (cfg_paddr == plt_pkg::ADDR_POINT_COUNT) ? {25'd0, point_count_r} :
                      run_delay_r;
  assign cfg_pready = 1'b1;

  plt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  plt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .run_delay   (run_delay_r),
    .point_count (point_count_r),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
`default_nettype wire
